// File: rtl/amf0vs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amf0vs_pkg
// shared types and constants of the amf0 value skipper
// ----------------------------------------------------------------------------
package amf0vs_pkg;

    localparam int MAX_NEST      = 16;
    localparam int DEPTH_W       = 5;
    localparam int LEN_W         = 32;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET = 5'd16;

    localparam logic [7:0] MK_NUMBER    = 8'h00;
    localparam logic [7:0] MK_BOOLEAN   = 8'h01;
    localparam logic [7:0] MK_STRING    = 8'h02;
    localparam logic [7:0] MK_OBJECT    = 8'h03;
    localparam logic [7:0] MK_NULL      = 8'h05;
    localparam logic [7:0] MK_UNDEFINED = 8'h06;
    localparam logic [7:0] MK_ECMA      = 8'h08;
    localparam logic [7:0] MK_OBJ_END   = 8'h09;
    localparam logic [7:0] MK_LSTRING   = 8'h0C;

    typedef enum logic [3:0] {
        PH_TYPE = 4'd0,
        PH_SLEN = 4'd1,
        PH_LLEN = 4'd2,
        PH_ECNT = 4'd3,
        PH_PAY  = 4'd4,
        PH_KLEN = 4'd5,
        PH_KEY  = 4'd6,
        PH_END  = 4'd7,
        PH_IDLE = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_TYPE = 3'd0,
        ROLE_LEN  = 3'd1,
        ROLE_PAY  = 3'd2,
        ROLE_KLEN = 3'd3,
        ROLE_KEY  = 3'd4,
        ROLE_END  = 3'd5,
        ROLE_IGN  = 3'd6
    } role_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_TYPE  = 2'd1,
        ERR_DEPTH = 2'd2
    } err_t;

    typedef struct packed {
        phase_t             phase;
        logic [LEN_W-1:0]   bytes_left;
        logic [1:0]         length_index;
        logic [DEPTH_W-1:0] depth;
        err_t               err;
    } state_t;

    typedef struct packed {
        role_t              role;
        logic [DEPTH_W-1:0] depth;
        logic               done;
        err_t               err;
    } result_t;

endpackage

// File: rtl/amf0vs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amf0vs_step
// next-state and result logic for one stream byte
// ----------------------------------------------------------------------------
module amf0vs_step (
    input  amf0vs_pkg::state_t                      state_cur,
    input  logic [7:0]                              data_byte,
    input  logic                                    start_value,
    input  logic [amf0vs_pkg::DEPTH_W-1:0]          max_depth,
    output amf0vs_pkg::state_t                      state_next,
    output amf0vs_pkg::result_t                     result
);

    typedef struct packed {
        amf0vs_pkg::state_t st;
        logic               done;
    } work_t;

    logic [amf0vs_pkg::DEPTH_W-1:0] limit;

    always_comb
    begin
        if ({3'd0, max_depth} > 8'(amf0vs_pkg::MAX_NEST))
        begin
            limit = amf0vs_pkg::DEPTH_W'(amf0vs_pkg::MAX_NEST);
        end
        else
        begin
            limit = max_depth;
        end
    end

    function automatic work_t finish_value(input work_t w);
        work_t r;
        r = w;
        if (w.st.depth != '0)
        begin
            r.st.phase        = amf0vs_pkg::PH_KLEN;
            r.st.length_index = 2'd1;
            r.st.bytes_left   = '0;
        end
        else
        begin
            r.st.phase = amf0vs_pkg::PH_IDLE;
            r.done     = 1'b1;
        end
        return r;
    endfunction

    function automatic work_t open_nest(input work_t w, input amf0vs_pkg::phase_t nph,
                                        input logic [1:0] idx,
                                        input logic [amf0vs_pkg::DEPTH_W-1:0] lim);
        work_t r;
        r = w;
        if (w.st.depth >= lim)
        begin
            r.st.err   = amf0vs_pkg::ERR_DEPTH;
            r.st.phase = amf0vs_pkg::PH_IDLE;
        end
        else
        begin
            r.st.depth        = w.st.depth + 1'b1;
            r.st.phase        = nph;
            r.st.length_index = idx;
            r.st.bytes_left   = '0;
        end
        return r;
    endfunction

    function automatic work_t take_type(input work_t w, input logic [7:0] b,
                                        input logic [amf0vs_pkg::DEPTH_W-1:0] lim);
        work_t r;
        r = w;
        unique case (b) inside
            amf0vs_pkg::MK_NUMBER:
            begin
                r.st.phase      = amf0vs_pkg::PH_PAY;
                r.st.bytes_left = 32'd8;
            end
            amf0vs_pkg::MK_BOOLEAN:
            begin
                r.st.phase      = amf0vs_pkg::PH_PAY;
                r.st.bytes_left = 32'd1;
            end
            amf0vs_pkg::MK_STRING:
            begin
                r.st.phase        = amf0vs_pkg::PH_SLEN;
                r.st.length_index = 2'd1;
                r.st.bytes_left   = '0;
            end
            amf0vs_pkg::MK_LSTRING:
            begin
                r.st.phase        = amf0vs_pkg::PH_LLEN;
                r.st.length_index = 2'd3;
                r.st.bytes_left   = '0;
            end
            amf0vs_pkg::MK_OBJECT: r = open_nest(w, amf0vs_pkg::PH_KLEN, 2'd1, lim);
            amf0vs_pkg::MK_ECMA:   r = open_nest(w, amf0vs_pkg::PH_ECNT, 2'd3, lim);
            amf0vs_pkg::MK_NULL, amf0vs_pkg::MK_UNDEFINED: r = finish_value(w);
            default:
            begin
                r.st.err   = amf0vs_pkg::ERR_TYPE;
                r.st.phase = amf0vs_pkg::PH_IDLE;
            end
        endcase
        return r;
    endfunction

    always_comb
    begin
        work_t               w;
        amf0vs_pkg::role_t   role;
        logic [31:0]         shifted;
        logic [31:0]         dec;

        w.st   = state_cur;
        w.done = 1'b0;
        if (start_value)
        begin
            w.st.phase        = amf0vs_pkg::PH_TYPE;
            w.st.bytes_left   = '0;
            w.st.length_index = '0;
            w.st.depth        = '0;
            w.st.err          = amf0vs_pkg::ERR_NONE;
        end

        shifted = {w.st.bytes_left[23:0], data_byte};
        dec     = (w.st.bytes_left != '0) ? (w.st.bytes_left - 32'd1) : w.st.bytes_left;
        role    = amf0vs_pkg::ROLE_IGN;

        unique case (w.st.phase) inside
            amf0vs_pkg::PH_TYPE:
            begin
                role = amf0vs_pkg::ROLE_TYPE;
                w    = take_type(w, data_byte, limit);
            end
            amf0vs_pkg::PH_SLEN, amf0vs_pkg::PH_LLEN, amf0vs_pkg::PH_ECNT:
            begin
                role            = amf0vs_pkg::ROLE_LEN;
                w.st.bytes_left = shifted;
                if (w.st.length_index == 2'd0)
                begin
                    if (w.st.phase == amf0vs_pkg::PH_ECNT)
                    begin
                        w.st.phase        = amf0vs_pkg::PH_KLEN;
                        w.st.length_index = 2'd1;
                        w.st.bytes_left   = '0;
                    end
                    else if (shifted == '0)
                    begin
                        w = finish_value(w);
                    end
                    else
                    begin
                        w.st.phase = amf0vs_pkg::PH_PAY;
                    end
                end
                else
                begin
                    w.st.length_index = w.st.length_index - 2'd1;
                end
            end
            amf0vs_pkg::PH_PAY:
            begin
                role            = amf0vs_pkg::ROLE_PAY;
                w.st.bytes_left = dec;
                if (dec == '0)
                begin
                    w = finish_value(w);
                end
            end
            amf0vs_pkg::PH_KLEN:
            begin
                role            = amf0vs_pkg::ROLE_KLEN;
                w.st.bytes_left = {16'd0, shifted[15:0]};
                if (w.st.length_index == 2'd0)
                begin
                    w.st.phase = (shifted[15:0] == 16'd0) ? amf0vs_pkg::PH_END
                                                          : amf0vs_pkg::PH_KEY;
                end
                else
                begin
                    w.st.length_index = w.st.length_index - 2'd1;
                end
            end
            amf0vs_pkg::PH_KEY:
            begin
                role            = amf0vs_pkg::ROLE_KEY;
                w.st.bytes_left = dec;
                if (dec == '0)
                begin
                    w.st.phase = amf0vs_pkg::PH_TYPE;
                end
            end
            amf0vs_pkg::PH_END:
            begin
                if (data_byte == amf0vs_pkg::MK_OBJ_END)
                begin
                    role = amf0vs_pkg::ROLE_END;
                    if (w.st.depth != '0)
                    begin
                        w.st.depth = w.st.depth - 1'b1;
                    end
                    w = finish_value(w);
                end
                else
                begin
                    role = amf0vs_pkg::ROLE_TYPE;
                    w    = take_type(w, data_byte, limit);
                end
            end
            default:
            begin
                role       = amf0vs_pkg::ROLE_IGN;
                w.st.phase = amf0vs_pkg::PH_IDLE;
            end
        endcase

        state_next   = w.st;
        result.role  = role;
        result.depth = w.st.depth;
        result.done  = w.done;
        result.err   = w.st.err;
    end

endmodule

// File: rtl/amf0vs_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amf0vs_out_buf
// result register with skid stage toward the output stream
// ----------------------------------------------------------------------------
module amf0vs_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  amf0vs_pkg::result_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output amf0vs_pkg::result_t   out_data
);

    logic                 main_valid_reg;
    logic                 main_valid_next;
    amf0vs_pkg::result_t  main_data_reg;
    amf0vs_pkg::result_t  main_data_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    amf0vs_pkg::result_t  skid_data_reg;
    amf0vs_pkg::result_t  skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        logic main_free;
        main_free       = !main_valid_reg || out_ready;
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = in_valid;
                main_data_next  = in_data;
            end
        end
        else if (in_valid && in_ready)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// File: rtl/amf0_value_skipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amf0_value_skipper
// byte-serial amf0 value structure tracker
// ----------------------------------------------------------------------------
// One stream byte is taken per clock unless stalled and yields a registered
// result: the byte's role, the nesting depth after it, a flag on the byte
// that ends the top-level value, and a sticky error code. The per-byte
// decode is a single pass of logic from the parse state register to the
// result register; a skid stage takes one more byte while the output is
// stalled. Set start_value (tuser) on the first marker of each new value.
// Write max_depth through the cfg channel only while idle; not enforced.
// ----------------------------------------------------------------------------
module amf0_value_skipper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,       // max_depth
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // data_byte
    input  logic        s_tuser,        // start_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,        // nest_depth[4:0], error_code[6:5], zero
    output logic [2:0]  m_tuser,        // byte_role
    output logic        m_tlast         // value_done
);

    amf0vs_pkg::state_t                 state_reg;
    amf0vs_pkg::state_t                 state_next;
    amf0vs_pkg::result_t                step_result;
    amf0vs_pkg::result_t                out_result;
    logic [amf0vs_pkg::DEPTH_W-1:0]     max_depth_reg;
    logic                               in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    amf0vs_step u_step (
        .state_cur   (state_reg),
        .data_byte   (s_tdata),
        .start_value (s_tuser),
        .max_depth   (max_depth_reg),
        .state_next  (state_next),
        .result      (step_result)
    );

    amf0vs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (step_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= amf0vs_pkg::PH_TYPE;
            state_reg.bytes_left   <= '0;
            state_reg.length_index <= '0;
            state_reg.depth        <= '0;
            state_reg.err          <= amf0vs_pkg::ERR_NONE;
            max_depth_reg          <= amf0vs_pkg::MAX_DEPTH_RESET;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                max_depth_reg <= cfg_data;
            end
        end
    end

    assign m_tdata = {1'b0, out_result.err, out_result.depth};
    assign m_tuser = out_result.role;
    assign m_tlast = out_result.done;

endmodule
